// File: hw/rtl/sci_pkg.sv
// ----------------------------------------------------------------------------
// sci_pkg
// Types and width constants shared by the segment/circle intersection unit.
// ----------------------------------------------------------------------------
package sci_pkg;

  // coordinate width of every coordinate field; the radius is one bit narrower
  localparam int CB = 16;
  // segment and offset differences
  localparam int DW = CB + 1;
  // a = d.d, unsigned
  localparam int AW = 2 * DW;
  // h = d.p and c = p.p - r^2, signed
  localparam int HW = AW + 1;
  // discriminant magnitude fed to the square root, even
  localparam int RW = 2 * HW - 2;
  // square root bits
  localparam int SW = RW / 2;
  // numerator -h +- s, signed
  localparam int NW = HW + 1;
  // numerator times a difference, signed
  localparam int PW = NW + DW;
  // rounding dividend 2|p| + a
  localparam int MW = PW + 1;
  // quotient bits kept; larger quotients lie outside the box
  localparam int QB = DW + 1;
  // rebuilt point, signed
  localparam int XW = QB + 2;

  typedef struct packed {
    logic signed [CB-1:0] start_x;
    logic signed [CB-1:0] start_y;
    logic signed [CB-1:0] end_x;
    logic signed [CB-1:0] end_y;
    logic signed [CB-1:0] centre_x;
    logic signed [CB-1:0] centre_y;
    logic        [CB-2:0] radius;
  } seg_item_t;

  typedef struct packed {
    logic                 first_valid;
    logic signed [CB-1:0] first_x;
    logic signed [CB-1:0] first_y;
    logic                 second_valid;
    logic signed [CB-1:0] second_x;
    logic signed [CB-1:0] second_y;
    logic                 degenerate;
  } seg_result_t;

endpackage

// File: hw/rtl/sci_sqrt_cell.sv
// ----------------------------------------------------------------------------
// sci_sqrt_cell
// One digit step of the floor square root: takes two radicand bits, tries
// the next root bit and hands remainder, root and radicand to the next cell.
// ----------------------------------------------------------------------------
module sci_sqrt_cell #(
  parameter int RW = sci_pkg::RW,
  parameter int SW = sci_pkg::SW
) (
  input  logic          clk,
  input  logic [RW-1:0] rad_in,
  input  logic [SW:0]   rem_in,
  input  logic [SW-1:0] root_in,
  output logic [RW-1:0] rad_out,
  output logic [SW:0]   rem_out,
  output logic [SW-1:0] root_out
);

  logic [SW+2:0] trial;
  logic [SW+2:0] test;
  logic [SW+2:0] diff;
  logic          fits;

  // bring down two bits and test against 4*root + 1
  always_comb begin
    trial = {rem_in, rad_in[RW-1 -: 2]};
    test  = {1'b0, root_in, 2'b01};
    fits  = trial >= test;
    diff  = trial - test;
  end

  // advance to the next cell
  always_ff @(posedge clk) begin
    rad_out  <= rad_in << 2;
    rem_out  <= fits ? diff[SW:0] : trial[SW:0];
    root_out <= {root_in[SW-2:0], fits};
  end

endmodule

// File: hw/rtl/sci_div_cell.sv
// ----------------------------------------------------------------------------
// sci_div_cell
// One quotient bit of the restoring divider: subtracts the shifted divisor
// when it fits and hands dividend residue, divisor and quotient onward.
// ----------------------------------------------------------------------------
module sci_div_cell #(
  parameter int MW  = sci_pkg::MW,
  parameter int AW  = sci_pkg::AW,
  parameter int QB  = sci_pkg::QB,
  parameter int BIT = 0
) (
  input  logic          clk,
  input  logic [MW-1:0] num_in,
  input  logic [AW:0]   den_in,
  input  logic [QB-1:0] quo_in,
  output logic [MW-1:0] num_out,
  output logic [AW:0]   den_out,
  output logic [QB-1:0] quo_out
);

  logic          fits;
  logic [QB-1:0] quo_next;

  // test the divisor at this bit weight
  always_comb begin
    fits          = (num_in >> BIT) >= MW'(den_in);
    quo_next      = quo_in;
    quo_next[BIT] = fits;
  end

  // advance to the next cell
  always_ff @(posedge clk) begin
    num_out <= fits ? num_in - (MW'(den_in) << BIT) : num_in;
    den_out <= den_in;
    quo_out <= quo_next;
  end

endmodule

// File: hw/rtl/segment_circle_intersection_unit.sv
// ----------------------------------------------------------------------------
// segment_circle_intersection_unit
// Intersects a segment with a circle by solving the quadratic exactly in
// wide integers, with a pipelined square root and rounding dividers.
// ----------------------------------------------------------------------------
//  channel  | handshake      | payload
//  ---------+----------------+--------------------------
//  command  | start / busy   | item   (sci_pkg::seg_item_t)
//  result   | done (strobe)  | result (sci_pkg::seg_result_t)
//
//  A new item is taken every cycle; busy stays low.
//  The pipeline holds six front stages, one square root cell per root bit,
//  three stages for the numerators, one divider cell per quotient bit, and
//  the output register. Reset clears the valid pipeline only; the receiver
//  cannot stall.
// ----------------------------------------------------------------------------
module segment_circle_intersection_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  sci_pkg::seg_item_t  item,
  output logic                done,
  output sci_pkg::seg_result_t result
);

  localparam int SW = sci_pkg::SW;
  localparam int QB = sci_pkg::QB;
  localparam int CB = sci_pkg::CB;
  localparam int DW = sci_pkg::DW;
  localparam int AW = sci_pkg::AW;
  localparam int HW = sci_pkg::HW;
  localparam int RW = 2 * SW;
  localparam int NW = sci_pkg::NW;
  localparam int PW = sci_pkg::PW;
  localparam int MW = sci_pkg::MW;
  localparam int XW = QB + 2;

  typedef struct packed {
    logic                 degen;
    logic                 neg;
    logic signed [CB-1:0] x1;
    logic signed [CB-1:0] y1;
    logic signed [CB-1:0] x2;
    logic signed [CB-1:0] y2;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic        [AW-1:0] a;
    logic signed [HW-1:0] h;
  } sq_side_t;

  typedef struct packed {
    logic                 degen;
    logic                 neg;
    logic signed [CB-1:0] x1;
    logic signed [CB-1:0] y1;
    logic signed [CB-1:0] x2;
    logic signed [CB-1:0] y2;
    logic        [3:0]    sgn;
    logic        [3:0]    ovf;
  } dv_side_t;

  // no backpressure on the command side
  assign busy = 1'b0;

  // --------------------------------------------------------------------------
  // front stages
  // --------------------------------------------------------------------------
  logic                 s0_vld;
  sci_pkg::seg_item_t   s0_item;

  logic                 s1_vld;
  logic signed [DW-1:0] s1_dx, s1_dy, s1_px, s1_py;
  logic        [CB-2:0] s1_r;
  logic signed [CB-1:0] s1_x1, s1_y1, s1_x2, s1_y2;

  logic                 s2_vld;
  logic signed [AW-1:0] s2_dxx, s2_dyy, s2_dxp, s2_dyp, s2_pxx, s2_pyy;
  logic [2*CB-3:0]      s2_rr;
  logic signed [DW-1:0] s2_dx, s2_dy;
  logic signed [CB-1:0] s2_x1, s2_y1, s2_x2, s2_y2;

  logic                 s3_vld;
  logic        [AW-1:0] s3_a;
  logic signed [HW-1:0] s3_h, s3_c;
  logic                 s3_degen;
  logic signed [DW-1:0] s3_dx, s3_dy;
  logic signed [CB-1:0] s3_x1, s3_y1, s3_x2, s3_y2;

  logic                   s4_vld;
  logic signed [2*HW-1:0] s4_hh, s4_ac;
  sq_side_t               s4_side;

  logic                   s5_vld;
  logic        [RW-1:0]   s5_rad;
  sq_side_t               s5_side;

  logic signed [2*HW-1:0] s5_disc;
  sq_side_t               s5_side_next;

  // control valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
      s4_vld <= 1'b0;
      s5_vld <= 1'b0;
    end else begin
      s0_vld <= start & ~busy;
      s1_vld <= s0_vld;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
      s4_vld <= s3_vld;
      s5_vld <= s4_vld;
    end
  end

  assign s5_disc = s4_hh - s4_ac;

  // flag a negative discriminant in the side data
  always_comb begin
    s5_side_next     = s4_side;
    s5_side_next.neg = s5_disc[2*HW-1];
  end

  // datapath of the front stages
  always_ff @(posedge clk) begin
    // capture the transfer
    s0_item <= item;

    // differences
    s1_dx <= DW'(s0_item.end_x) - DW'(s0_item.start_x);
    s1_dy <= DW'(s0_item.end_y) - DW'(s0_item.start_y);
    s1_px <= DW'(s0_item.start_x) - DW'(s0_item.centre_x);
    s1_py <= DW'(s0_item.start_y) - DW'(s0_item.centre_y);
    s1_r  <= s0_item.radius;
    s1_x1 <= s0_item.start_x;
    s1_y1 <= s0_item.start_y;
    s1_x2 <= s0_item.end_x;
    s1_y2 <= s0_item.end_y;

    // products
    s2_dxx <= s1_dx * s1_dx;
    s2_dyy <= s1_dy * s1_dy;
    s2_dxp <= s1_dx * s1_px;
    s2_dyp <= s1_dy * s1_py;
    s2_pxx <= s1_px * s1_px;
    s2_pyy <= s1_py * s1_py;
    s2_rr  <= s1_r * s1_r;
    s2_dx  <= s1_dx;
    s2_dy  <= s1_dy;
    s2_x1  <= s1_x1;
    s2_y1  <= s1_y1;
    s2_x2  <= s1_x2;
    s2_y2  <= s1_y2;

    // quadratic coefficients
    s3_a     <= AW'(unsigned'(s2_dxx)) + AW'(unsigned'(s2_dyy));
    s3_h     <= HW'(s2_dxp) + HW'(s2_dyp);
    s3_c     <= HW'(s2_pxx) + HW'(s2_pyy) - HW'(signed'({1'b0, s2_rr}));
    s3_degen <= (s2_dx == '0) && (s2_dy == '0);
    s3_dx    <= s2_dx;
    s3_dy    <= s2_dy;
    s3_x1    <= s2_x1;
    s3_y1    <= s2_y1;
    s3_x2    <= s2_x2;
    s3_y2    <= s2_y2;

    // discriminant products
    s4_hh         <= s3_h * s3_h;
    s4_ac         <= (2*HW)'(signed'({1'b0, s3_a})) * (2*HW)'(s3_c);
    s4_side.degen <= s3_degen;
    s4_side.neg   <= 1'b0;
    s4_side.x1    <= s3_x1;
    s4_side.y1    <= s3_y1;
    s4_side.x2    <= s3_x2;
    s4_side.y2    <= s3_y2;
    s4_side.dx    <= s3_dx;
    s4_side.dy    <= s3_dy;
    s4_side.a     <= s3_a;
    s4_side.h     <= s3_h;

    // discriminant; zero radicand when negative
    s5_side <= s5_side_next;
    s5_rad  <= s5_disc[2*HW-1] ? '0 : s5_disc[RW-1:0];
  end

  // --------------------------------------------------------------------------
  // square root chain
  // --------------------------------------------------------------------------
  logic [RW-1:0] sq_rad  [SW+1];
  logic [SW:0]   sq_rem  [SW+1];
  logic [SW-1:0] sq_root [SW+1];
  sq_side_t      sq_side [SW];
  logic [SW-1:0] sq_vld;

  assign sq_rad[0]  = s5_rad;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  for (genvar k = 0; k < SW; k++) begin : g_sqrt
    sci_sqrt_cell #(
      .RW (RW),
      .SW (SW)
    ) u_cell (
      .clk      (clk),
      .rad_in   (sq_rad[k]),
      .rem_in   (sq_rem[k]),
      .root_in  (sq_root[k]),
      .rad_out  (sq_rad[k+1]),
      .rem_out  (sq_rem[k+1]),
      .root_out (sq_root[k+1])
    );
  end

  // hold side data alongside the cells
  always_ff @(posedge clk) begin
    sq_side[0] <= s5_side;
    for (int k = 1; k < SW; k++) begin
      sq_side[k] <= sq_side[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld <= '0;
    end else begin
      sq_vld <= {sq_vld[SW-2:0], s5_vld};
    end
  end

  // --------------------------------------------------------------------------
  // numerators and rounding dividends
  // --------------------------------------------------------------------------
  sq_side_t             sq_end;
  logic                 s6_vld, s7_vld, s8_vld;
  logic signed [NW-1:0] s6_np, s6_nm;
  sq_side_t             s6_side;
  logic signed [PW-1:0] s7_p [4];
  logic        [AW-1:0] s7_a;
  dv_side_t             s7_side;
  logic        [MW-1:0] s8_num [4];
  logic        [AW:0]   s8_den;
  dv_side_t             s8_side;

  logic        [PW-1:0] s7_mag [4];
  logic        [MW-1:0] s7_dvd [4];
  dv_side_t             s8_side_next;

  assign sq_end = sq_side[SW-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_vld <= 1'b0;
      s7_vld <= 1'b0;
      s8_vld <= 1'b0;
    end else begin
      s6_vld <= sq_vld[SW-1];
      s7_vld <= s6_vld;
      s8_vld <= s7_vld;
    end
  end

  // magnitude, 2|p| + a, sign and overflow for each lane
  always_comb begin
    s8_side_next = s7_side;
    for (int l = 0; l < 4; l++) begin
      s7_mag[l] = s7_p[l][PW-1] ? PW'(-s7_p[l]) : PW'(s7_p[l]);
      s7_dvd[l] = (MW'(s7_mag[l]) << 1) + MW'(s7_a);
      s8_side_next.sgn[l] = s7_p[l][PW-1];
      s8_side_next.ovf[l] = (s7_dvd[l] >> QB) >= MW'({s7_a, 1'b0});
    end
  end

  always_ff @(posedge clk) begin
    // plus and minus numerators
    s6_np   <= NW'(signed'({1'b0, sq_root[SW]})) - NW'(sq_end.h);
    s6_nm   <= -NW'(sq_end.h) - NW'(signed'({1'b0, sq_root[SW]}));
    s6_side <= sq_end;

    // numerator times difference, lanes: first x, first y, second x, second y
    s7_p[0]       <= PW'(s6_np) * PW'(s6_side.dx);
    s7_p[1]       <= PW'(s6_np) * PW'(s6_side.dy);
    s7_p[2]       <= PW'(s6_nm) * PW'(s6_side.dx);
    s7_p[3]       <= PW'(s6_nm) * PW'(s6_side.dy);
    s7_a          <= s6_side.a;
    s7_side.degen <= s6_side.degen;
    s7_side.neg   <= s6_side.neg;
    s7_side.x1    <= s6_side.x1;
    s7_side.y1    <= s6_side.y1;
    s7_side.x2    <= s6_side.x2;
    s7_side.y2    <= s6_side.y2;
    s7_side.sgn   <= '0;
    s7_side.ovf   <= '0;

    // dividend, divisor 2a, and drop quotients too large for the box
    s8_den  <= {s7_a, 1'b0};
    s8_side <= s8_side_next;
    for (int l = 0; l < 4; l++) begin
      s8_num[l] <= s7_dvd[l];
    end
  end

  // --------------------------------------------------------------------------
  // divider chains, one per lane
  // --------------------------------------------------------------------------
  logic [QB-1:0] dv_quo [4];
  dv_side_t      dv_side [QB];
  logic [QB-1:0] dv_vld;

  for (genvar l = 0; l < 4; l++) begin : g_lane
    logic [MW-1:0] num [QB+1];
    logic [AW:0]   den [QB+1];
    logic [QB-1:0] quo [QB+1];

    assign num[0]    = s8_num[l];
    assign den[0]    = s8_den;
    assign quo[0]    = '0;
    assign dv_quo[l] = quo[QB];

    for (genvar k = 0; k < QB; k++) begin : g_div
      sci_div_cell #(
        .MW  (MW),
        .AW  (AW),
        .QB  (QB),
        .BIT (QB - 1 - k)
      ) u_cell (
        .clk     (clk),
        .num_in  (num[k]),
        .den_in  (den[k]),
        .quo_in  (quo[k]),
        .num_out (num[k+1]),
        .den_out (den[k+1]),
        .quo_out (quo[k+1])
      );
    end
  end

  // hold side data alongside the divider cells
  always_ff @(posedge clk) begin
    dv_side[0] <= s8_side;
    for (int k = 1; k < QB; k++) begin
      dv_side[k] <= dv_side[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_vld <= '0;
    end else begin
      dv_vld <= {dv_vld[QB-2:0], s8_vld};
    end
  end

  // --------------------------------------------------------------------------
  // rebuild points, box test, output register
  // --------------------------------------------------------------------------
  dv_side_t             dv_end;
  logic signed [XW-1:0] pt [4];
  logic signed [XW-1:0] base [4];
  logic signed [XW-1:0] off [4];
  logic                 in_box [2];
  logic                 ok [2];

  assign dv_end = dv_side[QB-1];

  always_comb begin
    base[0] = XW'(dv_end.x1);
    base[1] = XW'(dv_end.y1);
    base[2] = XW'(dv_end.x1);
    base[3] = XW'(dv_end.y1);
    for (int l = 0; l < 4; l++) begin
      off[l] = XW'(signed'({1'b0, dv_quo[l]}));
      pt[l]  = dv_end.sgn[l] ? base[l] - off[l] : base[l] + off[l];
    end
    for (int j = 0; j < 2; j++) begin
      in_box[j] = (XW'(dv_end.x1) <= pt[2*j])   && (pt[2*j]   <= XW'(dv_end.x2)) &&
                  (XW'(dv_end.y1) <= pt[2*j+1]) && (pt[2*j+1] <= XW'(dv_end.y2));
      ok[j]     = in_box[j] && !dv_end.degen && !dv_end.neg &&
                  !dv_end.ovf[2*j] && !dv_end.ovf[2*j+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_vld[QB-1];
    end
  end

  always_ff @(posedge clk) begin
    result.first_valid  <= ok[0];
    result.first_x      <= ok[0] ? pt[0][CB-1:0] : '0;
    result.first_y      <= ok[0] ? pt[1][CB-1:0] : '0;
    result.second_valid <= ok[1];
    result.second_x     <= ok[1] ? pt[2][CB-1:0] : '0;
    result.second_y     <= ok[1] ? pt[3][CB-1:0] : '0;
    result.degenerate   <= dv_end.degen;
  end

endmodule

// File: bench/tb_segment_circle_intersection_unit.sv
// ----------------------------------------------------------------------------
// tb_segment_circle_intersection_unit
// Self-checking bench for the segment/circle intersection unit. A directed
// table covers degenerate segments, misses, tangents, reversed segments and
// coordinate extremes. Random segments and circles follow, most of them
// built to cross. Every result is compared with a typed expectation or with
// a wide-integer predictor.
module tb_segment_circle_intersection_unit;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    sci_pkg::seg_item_t   item;
    bit                   typed;
    sci_pkg::seg_result_t expected;
  } stim_row_t;

  localparam int CB           = sci_pkg::CB;
  localparam int LATENCY      = 10 + sci_pkg::SW + sci_pkg::QB;
  localparam int RANDOM_ITEMS = 1030;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  sci_pkg::seg_item_t   item = '0;
  logic                 done;
  sci_pkg::seg_result_t result;

  // expectation attached to the item on the bus, when typed in by hand
  bit                   typed_now = 1'b0;
  sci_pkg::seg_result_t typed_value = '0;

  sci_pkg::seg_result_t pending_hits[$];
  stim_row_t            rows[$];
  int                   mismatches = 0;

  segment_circle_intersection_unit u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
  );

  always #5 clk = ~clk;

  // floor square root of a nonnegative wide value
  function automatic wide_t floor_sqrt(wide_t n);
    wide_t root, trial;
    root = 0;
    for (int b = 62; b >= 0; b--) begin
      trial = root | (wide_t'(1) <<< b);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  // round p / a to nearest, ties away from zero
  function automatic wide_t round_div(wide_t p, wide_t a);
    wide_t m, q;
    m = (p < 0) ? -p : p;
    q = (2 * m + a) / (2 * a);
    return (p < 0) ? -q : q;
  endfunction

  function automatic sci_pkg::seg_result_t predict_hits(sci_pkg::seg_item_t it);
    wide_t x1, y1, x2, y2, dx, dy, px, py, a, h, c, disc, root, num, ix, iy;
    sci_pkg::seg_result_t r;
    x1 = it.start_x;  y1 = it.start_y;
    x2 = it.end_x;    y2 = it.end_y;
    dx = x2 - x1;     dy = y2 - y1;
    px = x1 - wide_t'(it.centre_x);
    py = y1 - wide_t'(it.centre_y);
    a = dx * dx + dy * dy;
    h = dx * px + dy * py;
    c = px * px + py * py - wide_t'({1'b0, it.radius}) * wide_t'({1'b0, it.radius});
    r = '0;
    if (a == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    disc = h * h - a * c;
    if (disc < 0) return r;
    root = floor_sqrt(disc);
    for (int k = 0; k < 2; k++) begin
      num = (k == 0) ? -h + root : -h - root;
      ix = x1 + round_div(num * dx, a);
      iy = y1 + round_div(num * dy, a);
      if (x1 <= ix && ix <= x2 && y1 <= iy && iy <= y2) begin
        if (k == 0) begin
          r.first_valid = 1'b1;
          r.first_x = ix[CB-1:0];
          r.first_y = iy[CB-1:0];
        end else begin
          r.second_valid = 1'b1;
          r.second_x = ix[CB-1:0];
          r.second_y = iy[CB-1:0];
        end
      end
    end
    return r;
  endfunction

  function automatic sci_pkg::seg_item_t make_item(int sx, int sy, int ex, int ey,
                                                   int cx, int cy, int rad);
    sci_pkg::seg_item_t it;
    it.start_x = CB'(sx);   it.start_y = CB'(sy);
    it.end_x = CB'(ex);     it.end_y = CB'(ey);
    it.centre_x = CB'(cx);  it.centre_y = CB'(cy);
    it.radius = (CB-1)'(rad);
    return it;
  endfunction

  // append one row to the stimulus table
  function automatic void add_row(sci_pkg::seg_item_t it, bit typed,
                                  sci_pkg::seg_result_t exp_r);
    stim_row_t row;
    row.item = it;
    row.typed = typed;
    row.expected = exp_r;
    rows.insert(rows.size(), row);
  endfunction

  // segment running toward positive x and y with a circle close by
  function automatic sci_pkg::seg_item_t crossing_item();
    int span, sx, sy;
    span = ($urandom_range(0, 9) == 0) ? 30000 : 2000;
    sx = $urandom_range(0, 2 * span) - span;
    sy = $urandom_range(0, 2 * span) - span;
    return make_item(sx, sy,
                     sx + $urandom_range(0, span), sy + $urandom_range(0, span),
                     sx + $urandom_range(0, span) - span / 4,
                     sy + $urandom_range(0, span) - span / 4,
                     $urandom_range(0, span));
  endfunction

  function automatic sci_pkg::seg_item_t noise_item();
    return make_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom);
  endfunction

  // send one item; hold start until it is taken
  task automatic send_item(sci_pkg::seg_item_t it, bit typed,
                           sci_pkg::seg_result_t exp_r);
    start <= 1'b1;
    item <= it;
    typed_now <= typed;
    typed_value <= exp_r;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic idle_gap(bit allow);
    if (allow && $urandom_range(0, 99) < 16) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  // record expectations on each transfer and check each result
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy)
        pending_hits.insert(pending_hits.size(),
                            typed_now ? typed_value : predict_hits(item));
      if (done) begin
        if (pending_hits.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", result);
        end else begin
          sci_pkg::seg_result_t want;
          want = pending_hits.pop_front();
          if (want.first_valid !== result.first_valid ||
              want.first_x !== result.first_x || want.first_y !== result.first_y ||
              want.second_valid !== result.second_valid ||
              want.second_x !== result.second_x ||
              want.second_y !== result.second_y ||
              want.degenerate !== result.degenerate) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p got %p", want, result);
          end
        end
      end
    end
  end

  initial begin
    sci_pkg::seg_result_t zero_r, degen_r;
    zero_r = '0;
    degen_r = '0;
    degen_r.degenerate = 1'b1;

    // zero-length segments, typed expectations
    add_row(make_item(0, 0, 0, 0, 0, 0, 0), 1'b1, degen_r);
    add_row(make_item(-32768, 32767, -32768, 32767, 0, 0, 32767), 1'b1, degen_r);
    // circle far off the line: no intersection
    add_row(make_item(0, 0, 16, 0, 0, 1000, 0), 1'b1, zero_r);
    add_row(make_item(-32768, -32768, -32768, 32767, 32767, 0, 0), 1'b1, zero_r);
    // the rest through the predictor
    add_row(make_item(0, 0, 160, 0, 80, 0, 32), 1'b0, zero_r);       // two hits
    add_row(make_item(0, 0, 160, 0, 80, 32, 32), 1'b0, zero_r);      // tangent
    add_row(make_item(160, 0, 0, 0, 80, 0, 32), 1'b0, zero_r);       // reversed
    add_row(make_item(0, 160, 0, 0, 0, 80, 32), 1'b0, zero_r);       // reversed y
    add_row(make_item(0, 0, 160, 160, 0, 0, 64), 1'b0, zero_r);      // one hit
    add_row(make_item(-32768, -32768, 32767, 32767, 0, 0, 32767), 1'b0, zero_r);
    add_row(make_item(-32768, 0, 32767, 0, -32768, -32768, 32767), 1'b0, zero_r);
    add_row(make_item(32767, 32767, 32767, 32767, -32768, -32768, 32767), 1'b0,
            zero_r);
    add_row(make_item(-32768, -32768, 32767, 32767, 32767, -32768, 32767), 1'b0,
            zero_r);
    add_row(make_item(0, 0, 1, 1, 0, 0, 1), 1'b0, zero_r);
    add_row(make_item(-100, -100, 100, 100, 32767, 32767, 0), 1'b0, zero_r);

    // hold reset, then release it on a falling edge
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (rows[i]) begin
      send_item(rows[i].item, rows[i].typed, rows[i].expected);
      idle_gap(1'b1);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // drain the pipeline once before moving on
      if (n == 600) begin
        start <= 1'b0;
        while (pending_hits.size() != 0) @(posedge clk);
        @(negedge clk);
      end
      send_item(($urandom_range(0, 99) < 80) ? crossing_item() : noise_item(),
                1'b0, zero_r);
      // no idling across a long stretch
      idle_gap(!(n >= 250 && n < 450));
    end
    start <= 1'b0;
    typed_now <= 1'b0;

    while (pending_hits.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    if (mismatches == 0 && pending_hits.size() == 0)
      $display("** segment_circle_intersection_unit: PASSED **");
    else
      $display("** segment_circle_intersection_unit: FAILED **");
    $finish;
  end

  // stop a hung run
  initial begin
    #2ms;
    $display("** segment_circle_intersection_unit: FAILED **");
    $finish;
  end

endmodule
